/* rtl/core/sf5_pkg.sv */
// Shared constants, types and coefficients of the 5x5 sharpening filter.
package sf5_pkg;

    // Pixel and register field widths
    localparam int PIX_W          = 8;
    localparam int WIDTH_REG_W    = 13;
    localparam int HEIGHT_REG_W   = 14;
    localparam int CFG_DATA_W     = 14;
    localparam int CFG_IDX_W      = 4;
    localparam int IN_ROW_W       = HEIGHT_REG_W + 1;
    localparam int SF5_MAX_WIDTH  = 4096;

    // Output queue depth and credit counter width
    localparam int FIFO_DEPTH     = 8;
    localparam int CRED_W         = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // Kernel magnitudes; the diagonal and far taps carry negative weights
    localparam int COEF_CENTER = 848;   // center tap
    localparam int COEF_CROSS  = 115;   // four direct neighbors
    localparam int COEF_DIAG   = 61;    // four diagonal neighbors, negative
    localparam int COEF_FAR    = 21;    // four taps two steps straight out, negative
    localparam int COEF_KNIGHT = 3;     // eight knight-move taps
    localparam int COEF_CORNER = 5;     // four outer corners

    // Per-item decisions made at the accepting edge
    typedef struct packed {
        logic has_out;
        logic bypass;
        logic last;
    } sf5_ctrl_t;

    // New window column: index 0 is the oldest row, index 4 the incoming pixel
    typedef struct packed {
        logic                  valid;
        sf5_ctrl_t             ctrl;
        logic [4:0][PIX_W-1:0] pix;
    } sf5_col_t;

    // One result beat as stored in the output queue
    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_end;
    } sf5_beat_t;

    // Result leaving the arithmetic pipeline
    typedef struct packed {
        logic      valid;
        sf5_beat_t beat;
    } sf5_res_t;

endpackage

/* rtl/core/sf5_in_if.sv */
// Input pixel stream channel.
interface sf5_in_if import sf5_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;
    logic             flush;

    modport source (output valid, pixel_in, flush, input ready);
    modport sink (input valid, pixel_in, flush, output ready);
endinterface

/* rtl/core/sf5_out_if.sv */
// Output pixel stream channel.
interface sf5_out_if import sf5_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;

    modport source (output valid, pixel_out, frame_end, input ready);
    modport sink (input valid, pixel_out, frame_end, output ready);
endinterface

/* rtl/core/sharpen_filter_5x5.sv */
// Streaming 5x5 sharpening filter: frame counters, line store, arithmetic and output queue.
// Throughput: one item per cycle, set by the single read-modify-write port of the line store.
// The input stalls only while eight results are owed to the output queue.
// The output frame trails the input by two rows and two pixels; flush items drain the tail.
// Reset: counters zero, 64 by 64 frame, window zero; the line store is not cleared.
module sharpen_filter_5x5 import sf5_pkg::*; #(
    parameter int MAX_WIDTH = SF5_MAX_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    sf5_in_if.sink                video,
    sf5_out_if.source             filtered,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int XW    = (WID_W > WIDTH_REG_W) ? WID_W : WIDTH_REG_W;
    localparam int CW    = WID_W + 1;
    localparam int HX    = HEIGHT_REG_W + 1;

    logic [WIDTH_REG_W-1:0]  cfg_width_reg;
    logic [HEIGHT_REG_W-1:0] cfg_height_reg;
    logic [COL_W-1:0]        in_col_reg;
    logic [COL_W-1:0]        in_col_next;
    logic [IN_ROW_W-1:0]     in_row_reg;
    logic [IN_ROW_W-1:0]     in_row_next;
    logic [COL_W-1:0]        out_col_reg;
    logic [COL_W-1:0]        out_col_next;
    logic [HEIGHT_REG_W-1:0] out_row_reg;
    logic [HEIGHT_REG_W-1:0] out_row_next;
    logic [CRED_W-1:0]       credit_reg;

    logic [XW-1:0]           width_x;
    logic [WID_W-1:0]        w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;
    logic                    acc;
    logic                    pop;
    logic                    acc_res;
    logic                    cfg_hit;
    logic                    in_frame;
    logic                    lag_filled;
    logic                    in_wrap;
    logic                    out_wrap;
    logic [PIX_W-1:0]        pix_sel;
    sf5_ctrl_t               ctrl;
    sf5_col_t                col;
    sf5_res_t                res;

    // Effective frame size
    assign width_x = XW'(cfg_width_reg);
    always_comb
    begin
        priority if (cfg_width_reg == '0)
        begin
            w_eff = WID_W'(1);
        end
        else if (width_x > XW'(MAX_WIDTH))
        begin
            w_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WID_W'(width_x);
        end
    end
    assign h_eff = (cfg_height_reg == '0) ? HEIGHT_REG_W'(1) : cfg_height_reg;

    // Handshakes and credit for results owed to the output queue
    assign video.ready = (credit_reg < CRED_W'(FIFO_DEPTH));
    assign acc         = video.valid && video.ready;
    assign pop         = filtered.valid && filtered.ready;
    assign acc_res     = acc && ctrl.has_out;
    assign cfg_hit     = cfg_we && ((cfg_index == REG_IMAGE_WIDTH)
                                 || (cfg_index == REG_IMAGE_HEIGHT));

    // Per-item decisions from the frame position
    always_comb
    begin
        in_frame = (in_row_reg < IN_ROW_W'(h_eff));
        pix_sel  = (!video.flush && in_frame) ? video.pixel_in : '0;
        if (w_eff == WID_W'(1))
        begin
            lag_filled = (in_row_reg >= IN_ROW_W'(4));
        end
        else
        begin
            lag_filled = (in_row_reg > IN_ROW_W'(2))
                      || ((in_row_reg == IN_ROW_W'(2)) && (in_col_reg >= COL_W'(2)));
        end
        ctrl.has_out = lag_filled;
        ctrl.bypass  = (out_row_reg < HEIGHT_REG_W'(2))
                    || ((HX'(out_row_reg) + HX'(2)) >= HX'(h_eff))
                    || (out_col_reg < COL_W'(2))
                    || ((CW'(out_col_reg) + CW'(2)) >= CW'(w_eff));
        ctrl.last    = (out_row_reg == (h_eff - HEIGHT_REG_W'(1)))
                    && (CW'(out_col_reg) == (CW'(w_eff) - CW'(1)));
        in_wrap      = ((CW'(in_col_reg) + CW'(1)) >= CW'(w_eff));
        out_wrap     = ((CW'(out_col_reg) + CW'(1)) >= CW'(w_eff));
    end

    // Next frame position
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        priority if (cfg_hit || (acc_res && ctrl.last))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (acc)
        begin
            if (in_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + IN_ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (ctrl.has_out)
            begin
                if (out_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + HEIGHT_REG_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    // Configuration, position and credit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= WIDTH_REG_W'(64);
            cfg_height_reg <= HEIGHT_REG_W'(64);
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            credit_reg     <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_IMAGE_WIDTH))
            begin
                cfg_width_reg <= cfg_data[WIDTH_REG_W-1:0];
            end
            if (cfg_we && (cfg_index == REG_IMAGE_HEIGHT))
            begin
                cfg_height_reg <= cfg_data[HEIGHT_REG_W-1:0];
            end
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            unique case ({acc_res, pop})
                2'b10:   credit_reg <= credit_reg + CRED_W'(1);
                2'b01:   credit_reg <= credit_reg - CRED_W'(1);
                default: credit_reg <= credit_reg;
            endcase
        end
    end

    sf5_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .acc   (acc),
        .addr  (in_col_reg),
        .pix   (pix_sel),
        .ctrl  (ctrl),
        .col   (col)
    );

    sf5_filter u_filter (
        .clk   (clk),
        .rst_n (rst_n),
        .col   (col),
        .res   (res)
    );

    sf5_out_fifo u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res),
        .deq   (filtered)
    );

    // Credit never exceeds the queue depth
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CRED_W'(FIFO_DEPTH))
        else $error("credit count above queue depth");

    // Every accepted item with a result reaches the queue
    a_result_arrives: assert property (@(posedge clk) disable iff (!rst_n)
        acc_res |-> ##4 res.valid)
        else $error("result lost in the pipeline");

    // No result appears without an accepted item behind it
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> $past(acc_res, 4))
        else $error("result without a source item");

    // A popped beat was covered by a credit
    a_pop_credit: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (credit_reg != '0))
        else $error("output beat without credit");

    // Input column stays inside the row
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(in_col_reg) < CW'(w_eff))
        else $error("input column beyond row width");

endmodule

/* rtl/core/sf5_line_buf.sv */
// Four-row line store with read-modify-write cascade and same-column forwarding.
module sf5_line_buf import sf5_pkg::*; #(
    parameter int MAX_WIDTH = SF5_MAX_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         acc,
    input  logic [$clog2(MAX_WIDTH)-1:0] addr,
    input  logic [PIX_W-1:0]             pix,
    input  sf5_ctrl_t                    ctrl,
    output sf5_col_t                     col
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int LINE_W = 4 * PIX_W;

    // Packed rows per column: bits [PIX_W-1:0] newest row, top byte oldest row
    logic [LINE_W-1:0] mem [MAX_WIDTH];
    logic [LINE_W-1:0] rd_reg;
    logic [LINE_W-1:0] fwd_data_reg;
    logic              fwd_reg;
    logic              s1_valid_reg;
    logic [COL_W-1:0]  s1_addr_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    sf5_ctrl_t         s1_ctrl_reg;

    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] wdata;

    // Take the write of the previous beat when it hit the same column
    assign line  = fwd_reg ? fwd_data_reg : rd_reg;
    // Age every row by one and insert the new pixel
    assign wdata = {line[3*PIX_W-1:0], s1_pix_reg};

    // Store port: write back the aged column, read the column of the new beat
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            mem[s1_addr_reg] <= wdata;
        end
        if (acc)
        begin
            rd_reg <= mem[addr];
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wdata;
        if (acc)
        begin
            s1_addr_reg <= addr;
            s1_pix_reg  <= pix;
            s1_ctrl_reg <= ctrl;
        end
    end

    // Stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= acc;
            fwd_reg      <= acc && s1_valid_reg && (s1_addr_reg == addr);
        end
    end

    // Hand the new window column on, oldest row first
    always_comb
    begin
        col.valid  = s1_valid_reg;
        col.ctrl   = s1_ctrl_reg;
        col.pix[0] = line[4*PIX_W-1:3*PIX_W];
        col.pix[1] = line[3*PIX_W-1:2*PIX_W];
        col.pix[2] = line[2*PIX_W-1:PIX_W];
        col.pix[3] = line[PIX_W-1:0];
        col.pix[4] = s1_pix_reg;
    end

endmodule

/* rtl/core/sf5_filter.sv */
// 5x5 window register and pipelined weighted sum with scaling and clamp.
module sf5_filter import sf5_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  sf5_col_t col,
    output sf5_res_t res
);

    localparam int G4_W  = PIX_W + 2;
    localparam int G8_W  = PIX_W + 3;
    localparam int POS_W = 19;
    localparam int NEG_W = 17;
    localparam int SHIFT = 10;
    localparam int Q_W   = POS_W - SHIFT;

    logic [PIX_W-1:0] win_reg [5][5];

    logic             v2_reg;
    sf5_ctrl_t        ctl2_reg;

    logic             v3_reg;
    logic             bypass3_reg;
    logic             last3_reg;
    logic [PIX_W-1:0] ctr3_reg;
    logic [G4_W-1:0]  cross3_reg;
    logic [G4_W-1:0]  diag3_reg;
    logic [G4_W-1:0]  far3_reg;
    logic [G8_W-1:0]  knight3_reg;
    logic [G4_W-1:0]  corner3_reg;

    logic             v4_reg;
    logic             bypass4_reg;
    logic             last4_reg;
    logic [PIX_W-1:0] ctr4_reg;
    logic [POS_W-1:0] pos4_reg;
    logic [NEG_W-1:0] neg4_reg;

    logic [G4_W-1:0]  cross_next;
    logic [G4_W-1:0]  diag_next;
    logic [G4_W-1:0]  far_next;
    logic [G8_W-1:0]  knight_next;
    logic [G4_W-1:0]  corner_next;
    logic [POS_W-1:0] pos_next;
    logic [NEG_W-1:0] neg_next;
    logic [POS_W-1:0] diff;
    logic [Q_W-1:0]   quot;
    logic [PIX_W-1:0] filt;

    // Shift the window left and insert the new column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 5; r++)
            begin
                for (int k = 0; k < 5; k++)
                begin
                    win_reg[r][k] <= '0;
                end
            end
        end
        else if (col.valid)
        begin
            for (int r = 0; r < 5; r++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    win_reg[r][k] <= win_reg[r][k+1];
                end
                win_reg[r][4] <= col.pix[r];
            end
        end
    end

    // Group taps that share a weight
    always_comb
    begin
        cross_next  = G4_W'(win_reg[1][2]) + G4_W'(win_reg[3][2])
                    + G4_W'(win_reg[2][1]) + G4_W'(win_reg[2][3]);
        diag_next   = G4_W'(win_reg[1][1]) + G4_W'(win_reg[1][3])
                    + G4_W'(win_reg[3][1]) + G4_W'(win_reg[3][3]);
        far_next    = G4_W'(win_reg[0][2]) + G4_W'(win_reg[4][2])
                    + G4_W'(win_reg[2][0]) + G4_W'(win_reg[2][4]);
        knight_next = G8_W'(win_reg[0][1]) + G8_W'(win_reg[0][3])
                    + G8_W'(win_reg[1][0]) + G8_W'(win_reg[1][4])
                    + G8_W'(win_reg[3][0]) + G8_W'(win_reg[3][4])
                    + G8_W'(win_reg[4][1]) + G8_W'(win_reg[4][3]);
        corner_next = G4_W'(win_reg[0][0]) + G4_W'(win_reg[0][4])
                    + G4_W'(win_reg[4][0]) + G4_W'(win_reg[4][4]);
    end

    // Weight the groups; positive and negative parts kept apart
    always_comb
    begin
        pos_next = POS_W'(ctr3_reg) * POS_W'(COEF_CENTER)
                 + POS_W'(cross3_reg) * POS_W'(COEF_CROSS)
                 + POS_W'(knight3_reg) * POS_W'(COEF_KNIGHT)
                 + POS_W'(corner3_reg) * POS_W'(COEF_CORNER);
        neg_next = NEG_W'(diag3_reg) * NEG_W'(COEF_DIAG)
                 + NEG_W'(far3_reg) * NEG_W'(COEF_FAR);
    end

    // Scale by 1024 and clamp; a negative sum gives zero
    always_comb
    begin
        diff = pos4_reg - POS_W'(neg4_reg);
        quot = diff[POS_W-1:SHIFT];
        if (pos4_reg < POS_W'(neg4_reg))
        begin
            filt = '0;
        end
        else if (quot > Q_W'(255))
        begin
            filt = '1;
        end
        else
        begin
            filt = quot[PIX_W-1:0];
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        ctl2_reg    <= col.ctrl;
        bypass3_reg <= ctl2_reg.bypass;
        last3_reg   <= ctl2_reg.last;
        ctr3_reg    <= win_reg[2][2];
        cross3_reg  <= cross_next;
        diag3_reg   <= diag_next;
        far3_reg    <= far_next;
        knight3_reg <= knight_next;
        corner3_reg <= corner_next;
        bypass4_reg <= bypass3_reg;
        last4_reg   <= last3_reg;
        ctr4_reg    <= ctr3_reg;
        pos4_reg    <= pos_next;
        neg4_reg    <= neg_next;
    end

    // Pipeline control; drop beats that give no result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= col.valid;
            v3_reg <= v2_reg && ctl2_reg.has_out;
            v4_reg <= v3_reg;
        end
    end

    // Border pixels pass through unchanged
    always_comb
    begin
        res.valid          = v4_reg;
        res.beat.pixel_out = bypass4_reg ? ctr4_reg : filt;
        res.beat.frame_end = last4_reg;
    end

endmodule

/* rtl/core/sf5_out_fifo.sv */
// Output queue that decouples the filter pipeline from the output handshake.
module sf5_out_fifo import sf5_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  sf5_res_t         push,
    sf5_out_if.source        deq
);

    localparam int AW = $clog2(FIFO_DEPTH);

    sf5_beat_t         buf_reg [FIFO_DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [CRED_W-1:0] count_reg;
    logic              pop;

    assign pop = deq.valid && deq.ready;

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            buf_reg[wr_ptr_reg] <= push.beat;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            unique case ({push.valid, pop})
                2'b10:   count_reg <= count_reg + CRED_W'(1);
                2'b01:   count_reg <= count_reg - CRED_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Present the head beat
    assign deq.valid     = (count_reg != '0);
    assign deq.pixel_out = buf_reg[rd_ptr_reg].pixel_out;
    assign deq.frame_end = buf_reg[rd_ptr_reg].frame_end;

endmodule
